@@ rtl/core/tpo_pkg.sv @@
`default_nettype none
package tpo_pkg;

  // default coordinate width, taken from the low bits of each 16-bit slot
  localparam int COORD_BITS_DEF = 16;
  localparam int SLOT_W         = 16;
  localparam int PT_W           = 2 * SLOT_W;
  localparam int N_PTS          = 6;
  localparam int IN_TDATA_W     = N_PTS * PT_W;
  localparam int OUT_TDATA_W    = 8;

  // sign of a cross product: both low means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

endpackage
`default_nettype wire

@@ rtl/core/triangle_pair_overlap_test_top.sv @@
`default_nettype none
// Triangle pair overlap test, separating-edge form. Each input transfer carries two
// 2D triangles (six points, x in the low half and y in the high half of each 32-bit
// word, each coordinate the low min(COORD_BITS,16) bits of its slot in two's
// complement) and yields one output transfer whose bit 0 is 1 when no edge of either
// triangle separates them. Touching or collinear contact counts as overlap, and a
// degenerate triangle separates nothing by its own edges. The pipeline takes one pair
// per cycle while the output is not stalled and has four register stages (edge and
// point differences, products, cross product signs, result). The product stage holds
// 40 exact multipliers of (coordinate width + 1) bits; ready moves back through the
// stages, so bubbles are squeezed out while the output waits.
module triangle_pair_overlap_test_top #(
  parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // tri1_p0 [31:0], tri1_p1 [63:32], tri1_p2 [95:64],
  // tri2_p0 [127:96], tri2_p1 [159:128], tri2_p2 [191:160]
  input  wire logic [tpo_pkg::IN_TDATA_W-1:0] in_tdata,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // may_overlap [0], zero fill [7:1]
  output      logic [tpo_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tpo_pkg::*;

  localparam int CW = (COORD_BITS > SLOT_W) ? SLOT_W : COORD_BITS;
  localparam int DW = CW + 1;      // difference width
  localparam int PW = 2 * DW;      // product width
  localparam int XW = PW + 1;      // cross product width

  function automatic logic signed [CW-1:0] coord(input logic [SLOT_W-1:0] slot);
    return $signed(slot[CW-1:0]);
  endfunction

  // stage valids and back-propagated ready
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: unpack points, edge vectors and point-to-edge-origin vectors
  // index s: 0 tests edges of triangle one, 1 tests edges of triangle two
  logic signed [CW-1:0] px [N_PTS];
  logic signed [CW-1:0] py [N_PTS];
  logic signed [DW-1:0] ux_nxt [2][3];
  logic signed [DW-1:0] uy_nxt [2][3];
  logic signed [DW-1:0] vx_nxt [2][3][3];
  logic signed [DW-1:0] vy_nxt [2][3][3];
  logic signed [DW-1:0] rx_nxt [2];
  logic signed [DW-1:0] ry_nxt [2];
  logic signed [DW-1:0] ux_r [2][3];
  logic signed [DW-1:0] uy_r [2][3];
  logic signed [DW-1:0] vx_r [2][3][3];
  logic signed [DW-1:0] vy_r [2][3][3];
  logic signed [DW-1:0] rx_r [2];
  logic signed [DW-1:0] ry_r [2];

  always_comb begin
    for (int i = 0; i < N_PTS; i++) begin
      px[i] = coord(in_tdata[PT_W*i +: SLOT_W]);
      py[i] = coord(in_tdata[PT_W*i + SLOT_W +: SLOT_W]);
    end
    for (int s = 0; s < 2; s++) begin
      // reference orientation vector: third vertex minus first
      rx_nxt[s] = DW'(px[3*s+2]) - DW'(px[3*s]);
      ry_nxt[s] = DW'(py[3*s+2]) - DW'(py[3*s]);
      for (int e = 0; e < 3; e++) begin
        ux_nxt[s][e] = DW'(px[3*s + ((e == 2) ? 0 : e + 1)]) - DW'(px[3*s+e]);
        uy_nxt[s][e] = DW'(py[3*s + ((e == 2) ? 0 : e + 1)]) - DW'(py[3*s+e]);
        for (int j = 0; j < 3; j++) begin
          vx_nxt[s][e][j] = DW'(px[3*(1-s)+j]) - DW'(px[3*s+e]);
          vy_nxt[s][e][j] = DW'(py[3*(1-s)+j]) - DW'(py[3*s+e]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end
  end

  // stage 2: exact products of the cross product terms
  logic signed [PW-1:0] pa_nxt [2][3][3];
  logic signed [PW-1:0] pb_nxt [2][3][3];
  logic signed [PW-1:0] ra_nxt [2];
  logic signed [PW-1:0] rb_nxt [2];
  logic signed [PW-1:0] pa_r [2][3][3];
  logic signed [PW-1:0] pb_r [2][3][3];
  logic signed [PW-1:0] ra_r [2];
  logic signed [PW-1:0] rb_r [2];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      ra_nxt[s] = PW'(ux_r[s][0]) * PW'(ry_r[s]);
      rb_nxt[s] = PW'(uy_r[s][0]) * PW'(rx_r[s]);
      for (int e = 0; e < 3; e++) begin
        for (int j = 0; j < 3; j++) begin
          pa_nxt[s][e][j] = PW'(ux_r[s][e]) * PW'(vy_r[s][e][j]);
          pb_nxt[s][e][j] = PW'(uy_r[s][e]) * PW'(vx_r[s][e][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  // stage 3: cross product signs
  sgn_t sg_nxt [2][3][3];
  sgn_t rs_nxt [2];
  sgn_t sg_r [2][3][3];
  sgn_t rs_r [2];
  logic signed [XW-1:0] cr [2][3][3];
  logic signed [XW-1:0] rc [2];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      rc[s]         = XW'(ra_r[s]) - XW'(rb_r[s]);
      rs_nxt[s].neg = rc[s][XW-1];
      rs_nxt[s].pos = !rc[s][XW-1] && (|rc[s]);
      for (int e = 0; e < 3; e++) begin
        for (int j = 0; j < 3; j++) begin
          cr[s][e][j]         = XW'(pa_r[s][e][j]) - XW'(pb_r[s][e][j]);
          sg_nxt[s][e][j].neg = cr[s][e][j][XW-1];
          sg_nxt[s][e][j].pos = !cr[s][e][j][XW-1] && (|cr[s][e][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sg_r <= sg_nxt;
      rs_r <= rs_nxt;
    end
  end

  // stage 4: an edge separates when every other vertex is strictly opposite
  logic sep;
  logic out_bit_r;

  always_comb begin
    sep = 1'b0;
    for (int s = 0; s < 2; s++) begin
      for (int e = 0; e < 3; e++) begin
        if (rs_r[s].pos && sg_r[s][e][0].neg && sg_r[s][e][1].neg && sg_r[s][e][2].neg)
          sep = 1'b1;
        if (rs_r[s].neg && sg_r[s][e][0].pos && sg_r[s][e][1].pos && sg_r[s][e][2].pos)
          sep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      out_bit_r <= !sep;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_bit_r};

  // an accepted pair always lands in the first stage
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted pair not held in first stage");

  // empty output means the whole pipe can move
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a blocked product stage keeps its item
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("product stage dropped a stalled item");

  // two degenerate triangles can never be separated
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4 && !rs_r[0].pos && !rs_r[0].neg && !rs_r[1].pos && !rs_r[1].neg)
      |=> out_tdata[0])
    else $error("degenerate pair reported disjoint");

endmodule
`default_nettype wire
